/* src/qse_pkg.sv */
// Shared types, widths and constants of the queens solution enumerator.
package qse_pkg;

  localparam int SZ_W         = 4;   // board size and row arithmetic width
  localparam int COL_W        = 4;   // stored column width, holds the empty code
  localparam int PLACE_BITS   = 3;   // packed column width per row
  localparam int PLACE_W      = 24;  // packed placement width
  localparam int NUM_W        = 8;   // solution counter width
  localparam int MAX_SIZE_DEF = 8;   // default largest board

  localparam logic [COL_W-1:0] EMPTY_COL   = 4'd8;
  localparam logic [SZ_W-1:0]  BOARD_RESET = 4'd8;
  localparam logic [NUM_W-1:0] NUM_MAX     = 8'd255;

  typedef logic [COL_W-1:0] col_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage

/* src/qse_if.sv */
// Valid/ready channel interfaces for requests and results.
interface qse_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface qse_res_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [qse_pkg::PLACE_W-1:0] placement;
  logic [qse_pkg::NUM_W-1:0]   solution_number;

  modport source (output valid, output found, output placement, output solution_number,
                  input ready);
  modport sink   (input valid, input found, input placement, input solution_number,
                  output ready);
endinterface

/* src/queens_solution_enumerator.sv */
// Top level of the queens solution enumerator: size register and search sequencer.
//
// Usage: each request transaction on in_ch carries restart. With restart set the
// board and the solution counter are cleared first; otherwise the search resumes
// from the board kept after the previous solution. Exactly one result transaction
// follows on out_ch: found with the packed placement (three bits per row, row 0 in
// the low bits) and the running solution number, or found low when the search is
// exhausted. Requests after exhaustion keep answering not-found until a restart.
// The user must write the board size through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. Zero counts as one and
// values above MAX_SIZE count as MAX_SIZE.
// Search: after a request is accepted, each search step tests one candidate
// column or backtracks. The step that places the last queen also loads the result
// register; an exhausted search first sets the exhausted flag and loads the
// not-found result in a later step. The conflict checker tests one candidate
// against all placed queens each cycle.
// A new request is taken once the search has finished, even while the last
// result still waits; the search stalls on its final step if the receiver is
// still holding the previous result. Reset empties the board, clears the counter
// and sets the board size to eight.
module queens_solution_enumerator #(
  parameter int MAX_SIZE = qse_pkg::MAX_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  qse_req_if.sink                  in_ch,
  qse_res_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [qse_pkg::SZ_W-1:0] cfg_wdata
);

  logic [qse_pkg::SZ_W-1:0] board_size_r, board_size_nxt;
  logic [qse_pkg::SZ_W-1:0] size_n;

  always_comb begin
    board_size_nxt = board_size_r;
    if (cfg_we) begin
      board_size_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= qse_pkg::BOARD_RESET;
    end else begin
      board_size_r <= board_size_nxt;
    end
  end

  // Effective board size, clamped to the supported range.
  always_comb begin
    if (board_size_r == '0) begin
      size_n = qse_pkg::SZ_W'(1);
    end else if (board_size_r > qse_pkg::SZ_W'(MAX_SIZE)) begin
      size_n = qse_pkg::SZ_W'(MAX_SIZE);
    end else begin
      size_n = board_size_r;
    end
  end

  qse_seq #(.MAX_SIZE(MAX_SIZE)) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .size_n (size_n)
  );

  a_found_numbered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.found) |-> out_ch.solution_number != '0)
    else $error("solution reported with a zero solution number");

endmodule

/* src/qse_conflict.sv */
// Conflict checker: tests one candidate square against all queens in earlier rows.
module qse_conflict #(
  parameter int MAX_SIZE = qse_pkg::MAX_SIZE_DEF
) (
  input  qse_pkg::col_t              qc [MAX_SIZE],
  input  logic [qse_pkg::SZ_W-1:0]   row,
  input  logic [qse_pkg::COL_W-1:0]  col,
  output logic                       safe
);

  logic [MAX_SIZE-1:0] hit;

  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_lane
    logic                      active;
    logic [qse_pkg::COL_W-1:0] dc;
    logic [qse_pkg::SZ_W-1:0]  dr;

    assign active = (qse_pkg::SZ_W'(i) < row) && (qc[i] != qse_pkg::EMPTY_COL);
    assign dc     = (qc[i] > col) ? (qc[i] - col) : (col - qc[i]);
    assign dr     = row - qse_pkg::SZ_W'(i);
    assign hit[i] = active && ((qc[i] == col) || (dc == dr));
  end

  assign safe = ~|hit;

endmodule

/* src/qse_seq.sv */
// Backtracking sequencer: board state, step control and the result register.
module qse_seq #(
  parameter int MAX_SIZE = qse_pkg::MAX_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  qse_req_if.sink                  in_ch,
  qse_res_if.source                out_ch,
  input  logic [qse_pkg::SZ_W-1:0] size_n
);

  localparam int ROW_W = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;

  qse_pkg::state_t state_r, state_nxt;

  qse_pkg::col_t               qc_r [MAX_SIZE];
  qse_pkg::col_t               qc_nxt [MAX_SIZE];
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [qse_pkg::COL_W-1:0]   ncol_r, ncol_nxt;
  logic [qse_pkg::NUM_W-1:0]   count_r, count_nxt;
  logic                        exh_r, exh_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [qse_pkg::PLACE_W-1:0] out_place_r, out_place_nxt;
  logic [qse_pkg::NUM_W-1:0]   out_num_r, out_num_nxt;

  logic                        accept;
  logic                        search_en;
  logic                        out_free;
  logic                        safe;
  logic [qse_pkg::SZ_W-1:0]    row_ext;
  logic                        col_fits;
  logic                        last_row;
  logic [ROW_W-1:0]            prev_row;
  logic [qse_pkg::PLACE_W-1:0] pack;

  assign row_ext  = qse_pkg::SZ_W'(row_r);
  assign col_fits = ncol_r < size_n;
  assign last_row = (row_ext + qse_pkg::SZ_W'(1)) == size_n;
  assign prev_row = row_r - ROW_W'(1);
  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;

  qse_conflict #(.MAX_SIZE(MAX_SIZE)) u_conflict (
    .qc   (qc_r),
    .row  (row_ext),
    .col  (ncol_r),
    .safe (safe)
  );

  // Placement as it stands once the candidate is placed in the current row.
  always_comb begin
    pack = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      if (qse_pkg::SZ_W'(i) < size_n) begin
        if (ROW_W'(i) == row_r) begin
          pack[i*qse_pkg::PLACE_BITS +: qse_pkg::PLACE_BITS] =
            ncol_r[qse_pkg::PLACE_BITS-1:0];
        end else begin
          pack[i*qse_pkg::PLACE_BITS +: qse_pkg::PLACE_BITS] =
            qc_r[i][qse_pkg::PLACE_BITS-1:0];
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qse_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = qse_pkg::ST_SEARCH;
        end
      end
      qse_pkg::ST_SEARCH: begin
        if (out_free && (exh_r || (col_fits && safe && last_row))) begin
          state_nxt = qse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qse_pkg::ST_IDLE;
    endcase
  end

  // State decode.
  always_comb begin
    in_ch.ready = 1'b0;
    search_en   = 1'b0;
    case (state_r)
      qse_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      qse_pkg::ST_SEARCH: search_en   = 1'b1;
      default: begin
        in_ch.ready = 1'b0;
        search_en   = 1'b0;
      end
    endcase
  end

  // One step per cycle unless out_free stalls it: try a column, descend or backtrack.
  always_comb begin
    qc_nxt        = qc_r;
    row_nxt       = row_r;
    ncol_nxt      = ncol_r;
    count_nxt     = count_r;
    exh_nxt       = exh_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_place_nxt = out_place_r;
    out_num_nxt   = out_num_r;

    if (accept) begin
      if (in_ch.restart) begin
        for (int i = 0; i < MAX_SIZE; i++) begin
          qc_nxt[i] = qse_pkg::EMPTY_COL;
        end
        row_nxt   = '0;
        ncol_nxt  = '0;
        count_nxt = '0;
        exh_nxt   = 1'b0;
      end else if (row_ext >= size_n) begin
        // The board shrank below the kept row.
        exh_nxt = 1'b1;
      end
    end else if (search_en) begin
      if (exh_r) begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_place_nxt = '0;
          out_num_nxt   = count_r;
        end
      end else if (!col_fits) begin
        if (row_r == '0) begin
          exh_nxt = 1'b1;
        end else begin
          row_nxt          = prev_row;
          ncol_nxt         = qc_r[prev_row] + qse_pkg::COL_W'(1);
          qc_nxt[prev_row] = qse_pkg::EMPTY_COL;
        end
      end else if (safe) begin
        if (last_row) begin
          // The last row is left empty so the next request resumes past this column.
          if (out_free) begin
            if (count_r != qse_pkg::NUM_MAX) begin
              count_nxt = count_r + qse_pkg::NUM_W'(1);
            end
            ncol_nxt      = ncol_r + qse_pkg::COL_W'(1);
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b1;
            out_place_nxt = pack;
            out_num_nxt   = (count_r != qse_pkg::NUM_MAX) ?
                            count_r + qse_pkg::NUM_W'(1) : count_r;
          end
        end else begin
          qc_nxt[row_r] = ncol_r;
          row_nxt       = row_r + ROW_W'(1);
          ncol_nxt      = '0;
        end
      end else begin
        ncol_nxt = ncol_r + qse_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qse_pkg::ST_IDLE;
      for (int i = 0; i < MAX_SIZE; i++) begin
        qc_r[i] <= qse_pkg::EMPTY_COL;
      end
      row_r       <= '0;
      ncol_r      <= '0;
      count_r     <= '0;
      exh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qc_r        <= qc_nxt;
      row_r       <= row_nxt;
      ncol_r      <= ncol_nxt;
      count_r     <= count_nxt;
      exh_r       <= exh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_place_r <= out_place_nxt;
    out_num_r   <= out_num_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.found           = out_found_r;
  assign out_ch.placement       = out_place_r;
  assign out_ch.solution_number = out_num_r;

  // Checks that the current row holds no queen; rows above it stay empty too.
  a_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    qc_r[row_r] == qse_pkg::EMPTY_COL)
    else $error("queen found in a row that is not yet placed");

  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == qse_pkg::ST_SEARCH)
    else $error("accepted request did not start a search");

  a_exh_report: assert property (@(posedge clk) disable iff (!rst_n)
    (search_en && exh_r && out_free) |=>
      (state_r == qse_pkg::ST_IDLE) && out_valid_r && !out_found_r)
    else $error("exhausted search did not report not-found");

endmodule
